// ===== hdl/tags_pkg.sv =====
package tags_pkg;

    // Coordinate format: signed fixed point with eight fraction bits.
    localparam int COORD_WIDTH = 20;
    localparam int LIGHT_WIDTH = 20;
    localparam int FIELD_WIDTH = 60;
    localparam int HIT_WIDTH   = 20;
    localparam int BARY_WIDTH  = 16;
    localparam int PIXEL_WIDTH = 32;

    // Internal widths; some are derived from the coordinate width.
    localparam int RW    = ((COORD_WIDTH > LIGHT_WIDTH) ? COORD_WIDTH : LIGHT_WIDTH) + 1;
    localparam int EW    = COORD_WIDTH + 1;
    localparam int NW    = 2 * EW + 1;
    localparam int NORM_BITS = 15;
    localparam int SW    = NORM_BITS + 1;
    localparam int PW    = 2 * SW;
    localparam int DW    = PW + 2;
    localparam int CRW   = PW + 1;
    localparam int CMW   = CRW - 1;
    localparam int SQW   = 2 * CMW;
    localparam int ROOTW = SQW / 2;
    localparam int SHW   = $clog2(NW);
    localparam int XW    = DW + 2;
    localparam int ZW    = 26;
    localparam int CORDIC_STEPS = 20;
    localparam int ATW   = 22;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [1:0] CFG_LIGHT_Z = 2'd2;

    // Barycentric 1.0 in Q0.15.
    localparam logic signed [BARY_WIDTH:0] BARY_ONE = 17'sd32768;

    // Angle to gray mapping constants.
    localparam logic signed [ZW-1:0] ANGLE_LO  = 26'sd983040;
    localparam logic signed [ZW-1:0] ANGLE_90  = 26'sd5898240;
    localparam logic [7:0]           GRAY_MAX  = 8'd255;
    localparam logic [7:0]           DEG_SPAN  = 8'd165;
    localparam logic [8:0]           SPAN_RECIP = 9'd397;
    localparam int                   QW        = 17;
    localparam int                   ESTW      = 10;
    localparam logic [QW-1:0]        Q_CLAMP   = 17'd42240;
    localparam logic [7:0]           ALPHA     = 8'hff;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] ray_origin;
        logic [FIELD_WIDTH-1:0] ray_direction;
        logic signed [HIT_WIDTH-1:0] hit_distance;
        logic signed [BARY_WIDTH-1:0] bary_u;
        logic signed [BARY_WIDTH-1:0] bary_v;
        logic [FIELD_WIDTH-1:0] vertex_one;
        logic [FIELD_WIDTH-1:0] vertex_two;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_WIDTH-1:0] pixel_color;
        logic                   inside_res;
    } out_item_t;

    typedef struct packed {
        logic                   in_tri;
        logic [2:0][RW-1:0]     r;
        logic [2:0][NW-1:0]     n;
    } geom_t;

    typedef struct packed {
        logic                   in_tri;
        logic                   zero;
        logic [SQW-1:0]         sq;
        logic signed [DW-1:0]   d;
    } mag_t;

    typedef struct packed {
        logic                   in_tri;
        logic                   zero;
        logic [ROOTW-1:0]       root;
        logic signed [DW-1:0]   d;
    } root_t;

    typedef struct packed {
        logic                   in_tri;
        logic                   zero;
        logic signed [ZW-1:0]   z;
    } angle_t;

    // One signed coordinate of a packed triple; the field is zero padded
    // so that any coordinate width reads within bounds.
    function automatic logic [COORD_WIDTH-1:0] coord_of(input logic [FIELD_WIDTH-1:0] f,
                                                       input int idx);
        logic [FIELD_WIDTH+3*COORD_WIDTH-1:0] w;
        w = {{(3*COORD_WIDTH){1'b0}}, f};
        return w[idx*COORD_WIDTH +: COORD_WIDTH];
    endfunction

    // Arctangent of 2^-i in degrees, Q.16.
    function automatic logic [ATW-1:0] atan_q16(input int idx);
        logic [ATW-1:0] a;
        case (idx)
            0:       a = 22'd2949120;
            1:       a = 22'd1740967;
            2:       a = 22'd919879;
            3:       a = 22'd466945;
            4:       a = 22'd234379;
            5:       a = 22'd117304;
            6:       a = 22'd58666;
            7:       a = 22'd29335;
            8:       a = 22'd14668;
            9:       a = 22'd7334;
            10:      a = 22'd3667;
            11:      a = 22'd1833;
            12:      a = 22'd917;
            13:      a = 22'd458;
            14:      a = 22'd229;
            15:      a = 22'd115;
            16:      a = 22'd57;
            17:      a = 22'd29;
            18:      a = 22'd14;
            19:      a = 22'd7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/tags_front.sv =====
module tags_front
    import tags_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [LIGHT_WIDTH-1:0] light_x,
    input  logic signed [LIGHT_WIDTH-1:0] light_y,
    input  logic signed [LIGHT_WIDTH-1:0] light_z,
    input  logic                          item_valid,
    input  in_item_t                      item,
    output logic                          geo_valid,
    output geom_t                         geo
);

    localparam int PSW = 2 * COORD_WIDTH - 7;

    logic signed [COORD_WIDTH-1:0]   org_c [3];
    logic signed [COORD_WIDTH-1:0]   dir_c [3];
    logic signed [COORD_WIDTH-1:0]   v1_c  [3];
    logic signed [COORD_WIDTH-1:0]   v2_c  [3];
    logic signed [COORD_WIDTH-1:0]   t_c;
    logic signed [BARY_WIDTH:0]      uv_sum;
    logic                            inside_c;

    logic signed [COORD_WIDTH-1:0]   org_reg  [3];
    logic signed [2*COORD_WIDTH-1:0] prod_reg [3];
    logic signed [COORD_WIDTH-1:0]   v1_reg   [3];
    logic signed [COORD_WIDTH-1:0]   v2_reg   [3];
    logic                            inside1_reg;
    logic                            valid1_reg;

    logic signed [PSW-1:0]           psum [3];
    logic signed [COORD_WIDTH-1:0]   p_c  [3];
    logic signed [LIGHT_WIDTH-1:0]   lt_c [3];
    logic signed [RW-1:0]            r_next  [3];
    logic signed [EW-1:0]            e1_next [3];
    logic signed [EW-1:0]            e2_next [3];

    logic signed [RW-1:0]            r2_reg  [3];
    logic signed [EW-1:0]            e1_reg  [3];
    logic signed [EW-1:0]            e2_reg  [3];
    logic                            inside2_reg;
    logic                            valid2_reg;

    logic signed [2*EW-1:0]          m_reg   [6];
    logic signed [RW-1:0]            r3_reg  [3];
    logic                            inside3_reg;
    logic                            valid3_reg;

    logic                            valid4_reg;
    geom_t                           geo_reg;
    geom_t                           geo_next;

    // Stage one: unpack, barycentric test and t times direction.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            org_c[k] = coord_of(item.ray_origin, k);
            dir_c[k] = coord_of(item.ray_direction, k);
            v1_c[k]  = coord_of(item.vertex_one, k);
            v2_c[k]  = coord_of(item.vertex_two, k);
        end
        t_c      = COORD_WIDTH'({{COORD_WIDTH{1'b0}}, item.hit_distance});
        uv_sum   = (BARY_WIDTH+1)'(item.bary_u) + (BARY_WIDTH+1)'(item.bary_v);
        inside_c = (item.bary_u > 0) && (item.bary_v > 0) && (uv_sum <= BARY_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                org_reg[k]  <= org_c[k];
                prod_reg[k] <= t_c * dir_c[k];
                v1_reg[k]   <= v1_c[k];
                v2_reg[k]   <= v2_c[k];
            end
            inside1_reg <= inside_c;
        end
    end

    // Stage two: hit point with saturation, light vector and edges.
    always_comb
    begin
        lt_c[0] = light_x;
        lt_c[1] = light_y;
        lt_c[2] = light_z;
        for (int k = 0; k < 3; k++)
        begin
            psum[k] = PSW'(org_reg[k]) + PSW'(prod_reg[k] >>> 8);
            if (&psum[k][PSW-1:COORD_WIDTH-1] || ~|psum[k][PSW-1:COORD_WIDTH-1])
            begin
                p_c[k] = psum[k][COORD_WIDTH-1:0];
            end
            else
            begin
                p_c[k] = {psum[k][PSW-1], {(COORD_WIDTH-1){~psum[k][PSW-1]}}};
            end
            r_next[k]  = RW'(p_c[k]) - RW'(lt_c[k]);
            e1_next[k] = EW'(v1_reg[k]) - EW'(p_c[k]);
            e2_next[k] = EW'(v2_reg[k]) - EW'(p_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r2_reg[k] <= r_next[k];
                e1_reg[k] <= e1_next[k];
                e2_reg[k] <= e2_next[k];
            end
            inside2_reg <= inside1_reg;
        end
    end

    // Stage three: the six partial products of the edge cross product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= e1_reg[1] * e2_reg[2];
            m_reg[1] <= e1_reg[2] * e2_reg[1];
            m_reg[2] <= e1_reg[2] * e2_reg[0];
            m_reg[3] <= e1_reg[0] * e2_reg[2];
            m_reg[4] <= e1_reg[0] * e2_reg[1];
            m_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int k = 0; k < 3; k++)
            begin
                r3_reg[k] <= r2_reg[k];
            end
            inside3_reg <= inside2_reg;
        end
    end

    // Stage four: normal components.
    always_comb
    begin
        geo_next.in_tri = inside3_reg;
        for (int k = 0; k < 3; k++)
        begin
            geo_next.r[k] = r3_reg[k];
            geo_next.n[k] = NW'(m_reg[2*k]) - NW'(m_reg[2*k+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg <= geo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= item_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    assign geo_valid = valid4_reg;
    assign geo       = geo_reg;

endmodule

// ===== hdl/tags_norm.sv =====
module tags_norm
    import tags_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  geo_valid,
    input  geom_t geo,
    output logic  mag_valid,
    output mag_t  mag
);

    localparam int NSTAGES = 7;

    logic [RW-1:0]           or_r_next;
    logic [NW-1:0]           or_n_next;
    logic [RW-1:0]           or_r_reg;
    logic [NW-1:0]           or_n_reg;
    geom_t                   geo1_reg;

    logic [SHW-1:0]          sr_next;
    logic [SHW-1:0]          sn_next;
    logic [SHW-1:0]          sr_reg;
    logic [SHW-1:0]          sn_reg;
    logic                    zero2_reg;
    geom_t                   geo2_reg;

    logic signed [SW-1:0]    rs_reg [3];
    logic signed [SW-1:0]    ns_reg [3];
    logic                    zero3_reg;
    logic                    inside3_reg;

    logic signed [PW-1:0]    pr_reg [9];
    logic                    zero4_reg;
    logic                    inside4_reg;

    logic signed [DW-1:0]    d5_reg;
    logic signed [CRW-1:0]   c5_reg [3];
    logic                    zero5_reg;
    logic                    inside5_reg;

    logic [CMW-1:0]          cm_c [3];
    logic [SQW-1:0]          sq6_reg [3];
    logic signed [DW-1:0]    d6_reg;
    logic                    zero6_reg;
    logic                    inside6_reg;

    mag_t                    mag_reg;
    logic [NSTAGES-1:0]      valid_reg;

    // Stage one: OR of the component magnitudes gives the leading one.
    always_comb
    begin
        or_r_next = '0;
        or_n_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            or_r_next = or_r_next | (geo.r[k][RW-1] ? (RW'(0) - geo.r[k]) : geo.r[k]);
            or_n_next = or_n_next | (geo.n[k][NW-1] ? (NW'(0) - geo.n[k]) : geo.n[k]);
        end
    end

    // Stage two: smallest right shift that brings each vector below 2^15.
    always_comb
    begin
        sr_next = '0;
        sn_next = '0;
        for (int j = NORM_BITS; j < RW; j++)
        begin
            if (or_r_reg[j])
            begin
                sr_next = SHW'(j - NORM_BITS + 1);
            end
        end
        for (int j = NORM_BITS; j < NW; j++)
        begin
            if (or_n_reg[j])
            begin
                sn_next = SHW'(j - NORM_BITS + 1);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cm_c[k] = c5_reg[k][CRW-1] ? CMW'(-c5_reg[k]) : CMW'(c5_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            or_r_reg <= or_r_next;
            or_n_reg <= or_n_next;
            geo1_reg <= geo;

            sr_reg    <= sr_next;
            sn_reg    <= sn_next;
            zero2_reg <= (or_r_reg == '0) || (or_n_reg == '0);
            geo2_reg  <= geo1_reg;

            // Stage three: floor shift of each component.
            for (int k = 0; k < 3; k++)
            begin
                rs_reg[k] <= SW'($signed(geo2_reg.r[k]) >>> sr_reg);
                ns_reg[k] <= SW'($signed(geo2_reg.n[k]) >>> sn_reg);
            end
            zero3_reg   <= zero2_reg;
            inside3_reg <= geo2_reg.in_tri;

            // Stage four: dot product terms and cross product terms.
            pr_reg[0] <= rs_reg[0] * ns_reg[0];
            pr_reg[1] <= rs_reg[1] * ns_reg[1];
            pr_reg[2] <= rs_reg[2] * ns_reg[2];
            pr_reg[3] <= rs_reg[1] * ns_reg[2];
            pr_reg[4] <= rs_reg[2] * ns_reg[1];
            pr_reg[5] <= rs_reg[2] * ns_reg[0];
            pr_reg[6] <= rs_reg[0] * ns_reg[2];
            pr_reg[7] <= rs_reg[0] * ns_reg[1];
            pr_reg[8] <= rs_reg[1] * ns_reg[0];
            zero4_reg   <= zero3_reg;
            inside4_reg <= inside3_reg;

            // Stage five: dot product and cross product.
            d5_reg    <= DW'(pr_reg[0]) + DW'(pr_reg[1]) + DW'(pr_reg[2]);
            c5_reg[0] <= CRW'(pr_reg[3]) - CRW'(pr_reg[4]);
            c5_reg[1] <= CRW'(pr_reg[5]) - CRW'(pr_reg[6]);
            c5_reg[2] <= CRW'(pr_reg[7]) - CRW'(pr_reg[8]);
            zero5_reg   <= zero4_reg;
            inside5_reg <= inside4_reg;

            // Stage six: squares of the cross product components.
            for (int k = 0; k < 3; k++)
            begin
                sq6_reg[k] <= SQW'(cm_c[k]) * SQW'(cm_c[k]);
            end
            d6_reg      <= d5_reg;
            zero6_reg   <= zero5_reg;
            inside6_reg <= inside5_reg;

            // Stage seven: squared length of the cross product.
            mag_reg.sq     <= sq6_reg[0] + sq6_reg[1] + sq6_reg[2];
            mag_reg.d      <= d6_reg;
            mag_reg.zero   <= zero6_reg;
            mag_reg.in_tri <= inside6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTAGES-2:0], geo_valid};
        end
    end

    assign mag_valid = valid_reg[NSTAGES-1];
    assign mag       = mag_reg;

endmodule

// ===== hdl/tags_isqrt.sv =====
module tags_isqrt
    import tags_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  mag_valid,
    input  mag_t  mag,
    output logic  root_valid,
    output root_t root
);

    // One result bit per stage, most significant first.
    logic [SQW-1:0]       rem_reg    [ROOTW];
    logic [ROOTW-1:0]     root_reg   [ROOTW];
    logic signed [DW-1:0] d_reg      [ROOTW];
    logic                 zero_reg   [ROOTW];
    logic                 inside_reg [ROOTW];
    logic [ROOTW-1:0]     valid_reg;

    logic [SQW-1:0]       rem_in     [ROOTW];
    logic [ROOTW-1:0]     root_in    [ROOTW];
    logic [SQW:0]         trial      [ROOTW];
    logic [SQW-1:0]       rem_next   [ROOTW];
    logic [ROOTW-1:0]     root_next  [ROOTW];

    always_comb
    begin
        for (int k = 0; k < ROOTW; k++)
        begin
            if (k == 0)
            begin
                rem_in[k]  = mag.sq;
                root_in[k] = '0;
            end
            else
            begin
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            // (root + 2^i)^2 - root^2 with i the bit decided here.
            trial[k] = ((SQW+1)'(root_in[k]) << (ROOTW - k))
                     + ((SQW+1)'(1) << (2 * (ROOTW - 1 - k)));
            if ({1'b0, rem_in[k]} >= trial[k])
            begin
                rem_next[k]  = SQW'({1'b0, rem_in[k]} - trial[k]);
                root_next[k] = root_in[k] | (ROOTW'(1) << (ROOTW - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOTW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                if (k == 0)
                begin
                    d_reg[k]      <= mag.d;
                    zero_reg[k]   <= mag.zero;
                    inside_reg[k] <= mag.in_tri;
                end
                else
                begin
                    d_reg[k]      <= d_reg[k-1];
                    zero_reg[k]   <= zero_reg[k-1];
                    inside_reg[k] <= inside_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ROOTW-2:0], mag_valid};
        end
    end

    assign root_valid  = valid_reg[ROOTW-1];
    assign root.root   = root_reg[ROOTW-1];
    assign root.d      = d_reg[ROOTW-1];
    assign root.zero   = zero_reg[ROOTW-1];
    assign root.in_tri = inside_reg[ROOTW-1];

endmodule

// ===== hdl/tags_cordic.sv =====
module tags_cordic
    import tags_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   root_valid,
    input  root_t  root,
    output logic   angle_valid,
    output angle_t angle
);

    localparam int NREG = CORDIC_STEPS + 1;

    logic signed [XW-1:0] x_reg [NREG];
    logic signed [XW-1:0] y_reg [NREG];
    logic signed [ZW-1:0] z_reg [NREG];
    logic                 zero_reg   [NREG];
    logic                 inside_reg [NREG];
    logic [NREG-1:0]      valid_reg;

    logic signed [XW-1:0] x_next [CORDIC_STEPS];
    logic signed [XW-1:0] y_next [CORDIC_STEPS];
    logic signed [ZW-1:0] z_next [CORDIC_STEPS];

    // Each stage rotates towards the x axis by one table angle.
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + ZW'(atan_q16(i));
            end
            else
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - ZW'(atan_q16(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A negative dot product starts a quarter turn in.
            if (root.d < 0)
            begin
                x_reg[0] <= XW'(root.root);
                y_reg[0] <= -XW'(root.d);
                z_reg[0] <= ANGLE_90;
            end
            else
            begin
                x_reg[0] <= XW'(root.d);
                y_reg[0] <= XW'(root.root);
                z_reg[0] <= '0;
            end
            zero_reg[0]   <= root.zero;
            inside_reg[0] <= root.in_tri;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i+1]      <= x_next[i];
                y_reg[i+1]      <= y_next[i];
                z_reg[i+1]      <= z_next[i];
                zero_reg[i+1]   <= zero_reg[i];
                inside_reg[i+1] <= inside_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NREG-2:0], root_valid};
        end
    end

    assign angle_valid  = valid_reg[NREG-1];
    assign angle.z      = z_reg[NREG-1];
    assign angle.zero   = zero_reg[NREG-1];
    assign angle.in_tri = inside_reg[NREG-1];

endmodule

// ===== hdl/triangle_angle_gray_shader.sv =====
// Gray angle shader for triangle hits. Each transfer on the input channel
// carries one hit (ray, hit distance, barycentrics and two vertices) and
// produces exactly one transfer on the output channel, in order. A hit
// that fails the barycentric test gives pixel_color 0 with inside_res 0;
// otherwise the colour is opaque gray, darker as the angle between the
// light-to-hit vector and the surface normal falls towards 15 degrees.
// The block is a 67-stage pipeline: 4 stages of geometry, 7 of scaling,
// dot and cross products, 32 for the integer square root (one result bit
// per stage), 21 for the CORDIC angle and 3 for the gray mapping. It takes
// one transfer per cycle while the output does not stall.
// The light position registers are written through the cfg_we port and
// should only be changed while no transfer is in flight.
module triangle_angle_gray_shader
    import tags_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [LIGHT_WIDTH-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data
);

    logic signed [LIGHT_WIDTH-1:0] light_x_reg;
    logic signed [LIGHT_WIDTH-1:0] light_y_reg;
    logic signed [LIGHT_WIDTH-1:0] light_z_reg;

    logic        hold;
    logic        en;
    logic        skid_full_reg;
    in_item_t    skid_reg;
    logic        entry_valid;
    in_item_t    entry;

    logic        geo_valid;
    geom_t       geo;
    logic        mag_valid;
    mag_t        mag;
    logic        root_valid;
    root_t       root;
    logic        angle_valid;
    angle_t      angle;

    logic signed [ZW-1:0]  w_c;
    logic [QW-1:0]         q1_reg;
    logic                  pos1_reg;
    logic                  zero1_reg;
    logic                  inside1_reg;
    logic                  valid1_reg;

    logic [ESTW-1:0]       est2_reg;
    logic [QW-1:0]         q2_reg;
    logic                  pos2_reg;
    logic                  zero2_reg;
    logic                  inside2_reg;
    logic                  valid2_reg;

    logic [QW:0]           rem_c;
    logic [ESTW-1:0]       num_c;
    logic [7:0]            gray_c;
    out_item_t             out_next;
    out_item_t             out_reg;
    logic                  out_valid_reg;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIGHT_X: light_x_reg <= cfg_data;
                CFG_LIGHT_Y: light_y_reg <= cfg_data;
                CFG_LIGHT_Z: light_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The whole pipeline freezes while a finished result waits at the
    // output. One more transfer is still taken into the skid register, so
    // the input never waits on the output in the same cycle.
    assign hold     = out_valid_reg && out_stall;
    assign en       = !hold;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (hold)
        begin
            if (in_valid && !skid_full_reg)
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else
        begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold && in_valid && !skid_full_reg)
        begin
            skid_reg <= in_data;
        end
    end

    assign entry_valid = skid_full_reg || in_valid;
    assign entry       = skid_full_reg ? skid_reg : in_data;

    tags_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .light_x    (light_x_reg),
        .light_y    (light_y_reg),
        .light_z    (light_z_reg),
        .item_valid (entry_valid),
        .item       (entry),
        .geo_valid  (geo_valid),
        .geo        (geo)
    );

    tags_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .geo_valid (geo_valid),
        .geo       (geo),
        .mag_valid (mag_valid),
        .mag       (mag)
    );

    tags_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .mag_valid  (mag_valid),
        .mag        (mag),
        .root_valid (root_valid),
        .root       (root)
    );

    tags_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .root_valid  (root_valid),
        .root        (root),
        .angle_valid (angle_valid),
        .angle       (angle)
    );

    // Gray = floor((angle - 15 deg) * 255 / 165 deg). The divide by 165 * 2^16
    // is split into a shift by 16 and a reciprocal multiply by 397 / 2^16,
    // which undershoots by at most one and is corrected in the last stage.
    assign w_c = angle.z - ANGLE_LO;

    always_comb
    begin
        rem_c  = (QW+1)'(q2_reg) - ((QW+1)'(est2_reg) * (QW+1)'(DEG_SPAN));
        num_c  = (rem_c >= (QW+1)'(DEG_SPAN)) ? (est2_reg + ESTW'(1)) : est2_reg;
        if (!pos2_reg || zero2_reg)
        begin
            gray_c = '0;
        end
        else if (q2_reg >= Q_CLAMP)
        begin
            gray_c = GRAY_MAX;
        end
        else
        begin
            gray_c = num_c[7:0];
        end
        out_next.inside_res  = inside2_reg;
        out_next.pixel_color = inside2_reg ? {ALPHA, gray_c, gray_c, gray_c} : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg      <= QW'((33'(w_c[ZW-2:0]) * 33'(GRAY_MAX)) >> 16);
            pos1_reg    <= angle.z > ANGLE_LO;
            zero1_reg   <= angle.zero;
            inside1_reg <= angle.in_tri;

            est2_reg    <= ESTW'(((QW+9)'(q1_reg) * (QW+9)'(SPAN_RECIP)) >> 16);
            q2_reg      <= q1_reg;
            pos2_reg    <= pos1_reg;
            zero2_reg   <= zero1_reg;
            inside2_reg <= inside1_reg;

            out_reg     <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg    <= angle_valid;
            valid2_reg    <= valid1_reg;
            out_valid_reg <= valid2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // A miss always carries a black, fully transparent word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.inside_res |-> out_data.pixel_color == '0)
        else $error("miss result carries a non-zero colour");

    // A hit is opaque with three equal channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.inside_res |->
            out_data.pixel_color[31:24] == ALPHA &&
            out_data.pixel_color[23:16] == out_data.pixel_color[15:8] &&
            out_data.pixel_color[15:8] == out_data.pixel_color[7:0])
        else $error("hit colour is not opaque gray");

    // A transfer taken while the output stalls is kept in the skid register.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold && in_valid && !skid_full_reg |=> skid_full_reg)
        else $error("transfer taken during output stall was not kept");

    // The skid register only fills while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(hold))
        else $error("skid register filled without an output stall");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

import tags_pkg::*;

// Scoreboard: predicts each pixel from the accepted hit and the
// light position, queues it, and compares it with what leaves the block.
class shade_board;
    out_item_t pending[$];
    longint light[3];
    int errors;
    int shaded;
    int outside;

    function new();
        light = '{0, 0, 0};
        errors = 0;
        shaded = 0;
        outside = 0;
    endfunction

    function void set_light(int idx, logic [LIGHT_WIDTH-1:0] val);
        if (idx < 3)
            light[idx] = longint'($signed(val));
    endfunction

    function longint coord(logic [FIELD_WIDTH-1:0] f, int k);
        logic [COORD_WIDTH-1:0] c;
        c = f[k*COORD_WIDTH +: COORD_WIDTH];
        return longint'($signed(c));
    endfunction

    // Block scaling: shift right with floor until every magnitude is below 2^15.
    function bit rescale(inout longint v[3]);
        longint unsigned m;
        longint unsigned a;
        int s;
        m = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            a = (v[k] < 0) ? longint'(-v[k]) : v[k];
            if (a > m)
                m = a;
        end
        if (m == 0)
            return 0;
        while ((m >> s) >= (64'd1 << NORM_BITS))
            s++;
        for (int k = 0; k < 3; k++)
            v[k] = v[k] >>> s;
        return 1;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function longint atan_step(int i);
        longint tbl[20];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tbl[i];
    endfunction

    function longint gray_level(longint r[3], longint n[3]);
        longint d, x, y, z, xo, num;
        longint c[3];
        longint unsigned sq;
        if (!rescale(r) || !rescale(n))
            return 0;
        d = r[0]*n[0] + r[1]*n[1] + r[2]*n[2];
        c[0] = r[1]*n[2] - r[2]*n[1];
        c[1] = r[2]*n[0] - r[0]*n[2];
        c[2] = r[0]*n[1] - r[1]*n[0];
        sq = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
        y = longint'(root_floor(sq));
        if (d < 0)
        begin
            x = y;
            y = -d;
            z = 90 * 65536;
        end
        else
        begin
            x = d;
            z = 0;
        end
        for (int i = 0; i < 20; i++)
        begin
            xo = x;
            if (y > 0)
            begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z += atan_step(i);
            end
            else
            begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z -= atan_step(i);
            end
        end
        if (z <= 15 * 65536)
            return 0;
        num = (z - 15 * 65536) * 255 / (165 * 65536);
        return (num > 255) ? 255 : num;
    endfunction

    function void note_hit(in_item_t it);
        longint t, u, v, lim, g;
        longint p[3], r[3], e1[3], e2[3], n[3];
        out_item_t exp_px;
        t = longint'(it.hit_distance);
        u = longint'(it.bary_u);
        v = longint'(it.bary_v);
        lim = 64'sd1 <<< (COORD_WIDTH - 1);
        if (!(u > 0 && v > 0 && u + v <= 32768))
        begin
            exp_px.pixel_color = '0;
            exp_px.inside_res = 1'b0;
            outside++;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[k] = coord(it.ray_origin, k) + ((t * coord(it.ray_direction, k)) >>> 8);
                if (p[k] > lim - 1)
                    p[k] = lim - 1;
                if (p[k] < -lim)
                    p[k] = -lim;
                r[k] = p[k] - light[k];
                e1[k] = coord(it.vertex_one, k) - p[k];
                e2[k] = coord(it.vertex_two, k) - p[k];
            end
            n[0] = e1[1]*e2[2] - e1[2]*e2[1];
            n[1] = e1[2]*e2[0] - e1[0]*e2[2];
            n[2] = e1[0]*e2[1] - e1[1]*e2[0];
            g = gray_level(r, n);
            exp_px.pixel_color = {ALPHA, g[7:0], g[7:0], g[7:0]};
            exp_px.inside_res = 1'b1;
            shaded++;
        end
        pending.push_back(exp_px);
    endfunction

    function void check_pixel(out_item_t got);
        out_item_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected pixel transfer, actual %h/%b", $realtime,
                     got.pixel_color, got.inside_res);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.pixel_color !== want.pixel_color)
        begin
            $display("%0t: pixel_color mismatch, expected %h, actual %h", $realtime,
                     want.pixel_color, got.pixel_color);
            errors++;
        end
        if (got.inside_res !== want.inside_res)
        begin
            $display("%0t: inside_res mismatch, expected %b, actual %b", $realtime,
                     want.inside_res, got.inside_res);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [LIGHT_WIDTH-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    shade_board board;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int hits_sent;

    triangle_angle_gray_shader uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    // The receiving side stalls at random; the level is chosen at each
    // falling edge so that it is settled well before the next rising edge.
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    // Every pixel transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_pixel(out_data);
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d pixels outstanding", $realtime,
                     board.pending.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [FIELD_WIDTH-1:0] pack_xyz(int x, int y, int z);
        logic [COORD_WIDTH-1:0] cx, cy, cz;
        cx = x[COORD_WIDTH-1:0];
        cy = y[COORD_WIDTH-1:0];
        cz = z[COORD_WIDTH-1:0];
        return {cz, cy, cx};
    endfunction

    // A coordinate triple near the origin, so that the geometry stays sane.
    function automatic logic [FIELD_WIDTH-1:0] near_field(int span);
        return pack_xyz($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                        $urandom_range(2*span) - span);
    endfunction

    // Writes one light register while the pipeline is empty.
    task automatic write_light(logic [1:0] idx, logic [LIGHT_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        board.set_light(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Waits until every predicted pixel has come back and the pipeline is drained.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offers one hit and holds it until the transfer completes. It is entered
    // and left at a falling edge, so hits can follow one another directly.
    task automatic send_hit(in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_hit(it);
        hits_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Mostly well-formed hits inside the triangle; a fifth are noise.
    task automatic send_random(int count);
        in_item_t it;
        logic [319:0] raw;
        int u;
        for (int i = 0; i < count; i++)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            it = raw[$bits(in_item_t)-1:0];
            if ($urandom_range(99) < 80)
            begin
                u = $urandom_range(32767, 1);
                it.bary_u = BARY_WIDTH'(u);
                it.bary_v = BARY_WIDTH'($urandom_range((32768 - u > 32767) ? 32767
                                                                           : 32768 - u, 1));
                if ($urandom_range(99) < 65)
                begin
                    it.ray_origin = near_field(4096);
                    it.ray_direction = near_field(512);
                    it.hit_distance = HIT_WIDTH'($urandom_range(2048));
                    it.vertex_one = near_field(8192);
                    it.vertex_two = near_field(8192);
                end
            end
            send_hit(it);
        end
    endtask

    task automatic send_directed();
        in_item_t it;
        // Hit point and light both at the origin: zero-length light vector.
        it = '0;
        it.bary_u = 16'sd100;
        it.bary_v = 16'sd100;
        it.vertex_one = pack_xyz(256, 0, 0);
        it.vertex_two = pack_xyz(0, 256, 0);
        send_hit(it);
        // Both vertices on the hit point: zero-length normal.
        it.ray_origin = pack_xyz(512, 512, 512);
        it.vertex_one = it.ray_origin;
        it.vertex_two = it.ray_origin;
        send_hit(it);
        // A triangle in the z = 256 plane, lit from straight behind and ahead.
        it.ray_origin = pack_xyz(0, 0, 256);
        it.vertex_one = pack_xyz(256, 0, 256);
        it.vertex_two = pack_xyz(0, 256, 256);
        send_hit(it);
        it.vertex_one = pack_xyz(0, 256, 256);
        it.vertex_two = pack_xyz(256, 0, 256);
        send_hit(it);
        // Light vector lying in the triangle plane, at 90 degrees.
        it.ray_origin = pack_xyz(256, 0, 0);
        it.vertex_one = pack_xyz(512, 0, 0);
        it.vertex_two = pack_xyz(256, 256, 0);
        send_hit(it);
        // Barycentric edges: the sum exactly one, just past it, zero and negative weights.
        it.bary_u = 16'sd32767;
        it.bary_v = 16'sd1;
        send_hit(it);
        it.bary_v = 16'sd2;
        send_hit(it);
        it.bary_u = 16'sd0;
        it.bary_v = 16'sd1;
        send_hit(it);
        it.bary_u = 16'sd1;
        it.bary_v = 16'sd0;
        send_hit(it);
        it.bary_u = -16'sd32768;
        it.bary_v = 16'sd32767;
        send_hit(it);
        it.bary_u = 16'sd32767;
        it.bary_v = -16'sd1;
        send_hit(it);
        it.bary_u = 16'sd16384;
        it.bary_v = 16'sd16384;
        send_hit(it);
        // Coordinate extremes, with the hit point saturating both ways.
        it.bary_u = 16'sd1;
        it.bary_v = 16'sd1;
        it.ray_origin = {3{20'h7ffff}};
        it.ray_direction = {3{20'h7ffff}};
        it.hit_distance = 20'sh7ffff;
        it.vertex_one = {3{20'h80000}};
        it.vertex_two = {20'h80000, 20'h7ffff, 20'h80000};
        send_hit(it);
        it.ray_origin = {3{20'h80000}};
        it.hit_distance = -20'sh80000;
        it.vertex_one = {3{20'h7ffff}};
        it.vertex_two = {20'h7ffff, 20'h80000, 20'h7ffff};
        send_hit(it);
        it.ray_direction = {3{20'h80000}};
        send_hit(it);
        it = '1;
        it.bary_u = 16'sd1;
        it.bary_v = 16'sd1;
        send_hit(it);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LIGHT_X;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        hits_sent = 0;
        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: reset light at the origin, no idling.
        send_directed();
        send_random(120);
        drain();

        // Phase two: light at the largest coordinates, sender mostly idle.
        write_light(CFG_LIGHT_X, 20'h7ffff);
        write_light(CFG_LIGHT_Y, 20'h7ffff);
        write_light(CFG_LIGHT_Z, 20'h7ffff);
        idle_pct = 79;
        send_random(125);
        drain();

        // Phase three: light at the most negative coordinates, receiver stalling.
        write_light(CFG_LIGHT_X, 20'h80000);
        write_light(CFG_LIGHT_Y, 20'h80000);
        write_light(CFG_LIGHT_Z, 20'h80000);
        idle_pct = 0;
        stall_pct = 79;
        send_random(125);
        drain();

        // Phase four: a light near the scene and an index the block ignores.
        write_light(CFG_LIGHT_X, 20'h00800);
        write_light(CFG_LIGHT_Y, 20'hff400);
        write_light(CFG_LIGHT_Z, 20'h01000);
        write_light(2'd3, 20'h12345);
        idle_pct = 17;
        stall_pct = 17;
        send_random(125);
        drain();

        // Phase five: random light, no idling again.
        write_light(CFG_LIGHT_X, LIGHT_WIDTH'($urandom()));
        write_light(CFG_LIGHT_Y, LIGHT_WIDTH'($urandom()));
        write_light(CFG_LIGHT_Z, LIGHT_WIDTH'($urandom()));
        idle_pct = 0;
        stall_pct = 0;
        send_random(125);
        drain();

        $display("Sent %0d hits over five light settings: %0d shaded, %0d outside.",
                 hits_sent, board.shaded, board.outside);
        $display("Idling covered none, sender only, receiver only and both sides.");
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
